FILE: rtl/core/rgb_led_command_controller_defines.svh
// Assertion macros shared by the LED command controller RTL.
`ifndef RGB_LED_COMMAND_CONTROLLER_DEFINES_SVH
`define RGB_LED_COMMAND_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define RLCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// ante implies cons in the following cycle
`define RLCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RLCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/core/rlcc_pkg.sv
// Shared types, codes and helpers of the LED command controller.
`timescale 1ns / 1ps

package rlcc_pkg;

    // input transaction
    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_char;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [1:0] line_status;
        logic       last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic char_upd;
        logic line_end;
        logic wheel_step;
        logic emit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic is_cr;
        logic out_free;
        logic frame_last;
    } t_dp_stat;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_STRIP  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_RAINBOW = 2'd0;
    localparam logic [1:0] ST_COLOR   = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    localparam logic [7:0] CHAR_CR   = 8'd13;
    localparam logic [7:0] CHAR_BS   = 8'd127;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_6    = 8'h36;
    localparam logic [7:0] CHAR_8    = 8'h38;

    localparam logic [7:0] COUNT_MAX    = 8'd255;
    localparam logic [7:0] RAINBOW_LEN  = 8'd12;
    localparam logic [7:0] COLOR_LEN    = 8'd9;

    localparam logic [7:0] RAINBOW_TEXT [12] = '{
        8'h23, 8'h46, 8'h55, 8'h4C, 8'h4C, 8'h52,
        8'h41, 8'h49, 8'h4E, 8'h42, 8'h4F, 8'h57
    };

    // LED header: three marker bits, then five brightness bits
    localparam logic [2:0] HDR_MARK     = 3'b111;
    localparam logic [4:0] BRIGHT_RESET = 5'd2;
    localparam logic [7:0] BYTE_START   = 8'h00;
    localparam logic [7:0] BYTE_END     = 8'hFF;

    // {ok, nibble}; ok low for a non-hex character
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        priority if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else begin
            res = 5'd0;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/rgb_led_command_controller.sv
// Top level of the serial-command APA102-style LED strip controller.
`timescale 1ns / 1ps
`include "rgb_led_command_controller_defines.svh"

// Each input transaction is either a received character (cmd 0) or a refresh
// tick (cmd 1). Characters build a command line of up to LINE_MAX characters
// (127 deletes one, a longer line is rejected); carriage return closes it and
// returns one status transaction: 0 for an exact "#FULLRAINBOW" (clears all
// colors, rainbow mode), 1 for "#RRGGBBDn" with n = 6..8 (sets LED n-6, static
// mode), 2 for anything else. A tick returns one strip frame of
// 8 + 4*NUM_LEDS bytes (20 at defaults): four 0x00, per LED {111,brightness},
// blue, green, red, then four 0xFF; last marks the final byte. In rainbow mode
// the tick first steps a ping-pong wheel position that colors every LED.
// One transaction is in work at a time. A tick's frame comes from the frame
// sequencer at one byte per cycle while the output register is free; output
// back-pressure can stall a carriage return and stretches a frame. The output register
// lets the next input transaction be taken while the last result waits.
// Brightness (reset 2) sits at APB address 0; there is no clearing pass.
module rgb_led_command_controller #(
    parameter int NUM_LEDS = 3,
    parameter int LINE_MAX = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rlcc_pkg::t_in_item  i_in_data,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rlcc_pkg::t_out_item o_out_data,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [1:0] ADDR_BRIGHT = 2'd0;

    logic [4:0]         r_brightness;
    logic [4:0]         n_brightness;
    rlcc_pkg::t_dp_cmd  w_cmd;
    rlcc_pkg::t_dp_stat w_stat;

    // APB: no wait states, write lands in the access phase
    assign pready = 1'b1;

    always_comb begin
        n_brightness = r_brightness;
        if (psel && penable && pwrite && (paddr == ADDR_BRIGHT)) begin
            n_brightness = pwdata[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= rlcc_pkg::BRIGHT_RESET;
        end else begin
            r_brightness <= n_brightness;
        end
    end

    assign prdata = (paddr == ADDR_BRIGHT) ? {27'd0, r_brightness} : 32'd0;

    // sequencer
    rlcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // line decode, color store, wheel, frame bytes and output register
    rlcc_datapath #(
        .NUM_LEDS (NUM_LEDS),
        .LINE_MAX (LINE_MAX)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_brightness (r_brightness),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

    // a result is only loaded when the output register can take it
    `RLCC_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_cmd.emit || w_cmd.line_end, w_stat.out_free, "result loaded into busy output register")
    // no input taken while a result is being produced
    `RLCC_ASSERT_IMP(a_ready_quiet, i_clk, i_rst_n, o_in_ready, !w_cmd.emit && !w_cmd.line_end, "input ready during result")
    // final frame byte returns the block to idle
    `RLCC_ASSERT_NXT(a_frame_done, i_clk, i_rst_n, w_cmd.emit && w_stat.frame_last, o_in_ready, "not idle after frame")
    // an accepted tick starts its frame with a wheel step
    `RLCC_ASSERT_NXT(a_tick_step, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_data.cmd, w_cmd.wheel_step, "tick without wheel step")

endmodule

FILE: rtl/core/rlcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rlcc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rlcc_ctrl.sv
// Sequencing state machine of the LED command controller.
`timescale 1ns / 1ps

module rlcc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output rlcc_pkg::t_dp_cmd  o_cmd,
    input  rlcc_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECODE = 3'b010,
        S_FRAME  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.is_tick) begin
                    o_cmd.wheel_step = 1'b1;
                    n_state          = S_FRAME;
                end else if (!i_stat.is_cr) begin
                    o_cmd.char_upd = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.line_end = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_DECODE;
                end
            end
            S_FRAME: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.frame_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/rlcc_datapath.sv
// Line buffer, command decode, color store, wheel and frame byte datapath.
`timescale 1ns / 1ps

module rlcc_datapath #(
    parameter int NUM_LEDS = 3,
    parameter int LINE_MAX = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlcc_pkg::t_in_item  i_in_data,
    input  logic [4:0]          i_brightness,
    input  rlcc_pkg::t_dp_cmd   i_cmd,
    output rlcc_pkg::t_dp_stat  o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output rlcc_pkg::t_out_item o_out_data
);

    localparam int LED_W       = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int IDX_W       = $clog2(LINE_MAX);
    localparam int FRAME_BYTES = 8 + 4 * NUM_LEDS;
    localparam int BYTE_W      = $clog2(FRAME_BYTES);
    localparam logic [BYTE_W-1:0] LED_FIRST = BYTE_W'(4);
    localparam logic [BYTE_W-1:0] LED_END   = BYTE_W'(FRAME_BYTES - 4);
    localparam logic [BYTE_W-1:0] BYTE_LAST = BYTE_W'(FRAME_BYTES - 1);
    localparam logic [7:0]        LINE_LIM  = 8'(LINE_MAX);

    // payload
    rlcc_pkg::t_in_item  r_item;
    logic [7:0]          r_line [LINE_MAX];
    rlcc_pkg::t_out_item r_out;
    rlcc_pkg::t_out_item n_out;

    // control
    logic [7:0]          r_count, n_count;
    logic [NUM_LEDS-1:0] r_led_valid, n_led_valid;
    logic                r_rainbow, n_rainbow;
    logic [7:0]          r_wheel_pos, n_wheel_pos;
    logic                r_sweep_down, n_sweep_down;
    logic [BYTE_W-1:0]   r_byte_idx, n_byte_idx;
    logic                r_out_valid, n_out_valid;

    // line decode
    logic       rainbow_hit;
    logic       color_hit;
    logic       hex_ok;
    logic       line_long;
    logic [4:0] hx [6];
    logic [23:0] rgb;
    logic [1:0] led_sel;
    logic       led_in_range;
    logic [1:0] line_status;
    logic       color_we;
    logic       buf_we;

    always_comb begin
        rainbow_hit = (r_count == rlcc_pkg::RAINBOW_LEN);
        for (int k = 0; k < 12; k++) begin
            if (r_line[k] != rlcc_pkg::RAINBOW_TEXT[k]) begin
                rainbow_hit = 1'b0;
            end
        end
        hex_ok = 1'b1;
        for (int k = 0; k < 6; k++) begin
            hx[k] = rlcc_pkg::hex_decode(r_line[k + 1]);
            if (!hx[k][4]) begin
                hex_ok = 1'b0;
            end
        end
        rgb = {hx[0][3:0], hx[1][3:0], hx[2][3:0], hx[3][3:0], hx[4][3:0], hx[5][3:0]};
        color_hit = (r_count == rlcc_pkg::COLOR_LEN) && (r_line[0] == rlcc_pkg::CHAR_HASH)
                 && (r_line[7] == rlcc_pkg::CHAR_D) && (r_line[8] >= rlcc_pkg::CHAR_6)
                 && (r_line[8] <= rlcc_pkg::CHAR_8) && hex_ok;
        led_sel      = 2'(r_line[8] - rlcc_pkg::CHAR_6);
        led_in_range = ({30'd0, led_sel} < 32'(NUM_LEDS));
        line_long    = (r_count > LINE_LIM);
        priority if (line_long) begin
            line_status = rlcc_pkg::ST_REJECT;
        end else if (rainbow_hit) begin
            line_status = rlcc_pkg::ST_RAINBOW;
        end else if (color_hit) begin
            line_status = rlcc_pkg::ST_COLOR;
        end else begin
            line_status = rlcc_pkg::ST_REJECT;
        end
    end

    assign color_we = i_cmd.line_end && (line_status == rlcc_pkg::ST_COLOR) && led_in_range;
    assign buf_we   = i_cmd.char_upd && (r_item.rx_char != rlcc_pkg::CHAR_BS)
                   && (r_count < LINE_LIM);

    // rainbow wheel: p = 255 - pos, three linear segments
    logic [7:0] wp;
    logic [7:0] wseg;
    logic [9:0] w3;
    logic [23:0] wheel_rgb;

    always_comb begin
        wp = 8'd255 - r_wheel_pos;
        priority if (wp < 8'd85) begin
            wseg = wp;
        end else if (wp < 8'd170) begin
            wseg = wp - 8'd85;
        end else begin
            wseg = wp - 8'd170;
        end
        w3 = {2'b00, wseg} + {1'b0, wseg, 1'b0};
        priority if (wp < 8'd85) begin
            wheel_rgb = {8'd255 - w3[7:0], 8'd0, w3[7:0]};
        end else if (wp < 8'd170) begin
            wheel_rgb = {8'd0, w3[7:0], 8'd255 - w3[7:0]};
        end else begin
            wheel_rgb = {w3[7:0], 8'd255 - w3[7:0], 8'd0};
        end
    end

    // frame byte select
    logic [BYTE_W-1:0] led_ofs;
    logic [1:0]        phase;
    logic              in_leds;
    logic [LED_W-1:0]  led_addr;
    logic [23:0]       ram_rgb;
    logic [23:0]       led_rgb;
    logic [7:0]        frame_byte;
    logic              frame_last;

    assign led_ofs    = r_byte_idx - LED_FIRST;
    assign phase      = led_ofs[1:0];
    assign in_leds    = (r_byte_idx >= LED_FIRST) && (r_byte_idx < LED_END);
    assign led_addr   = in_leds ? LED_W'(led_ofs[BYTE_W-1:2]) : '0;
    assign frame_last = (r_byte_idx == BYTE_LAST);

    // color row address is set at the LED's header byte, so the registered read data is ready for its blue byte
    rlcc_ram #(
        .WIDTH (24),
        .DEPTH (NUM_LEDS)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (color_we),
        .i_waddr (LED_W'(led_sel)),
        .i_wdata (rgb),
        .i_raddr (led_addr),
        .o_rdata (ram_rgb)
    );

    always_comb begin
        if (r_rainbow) begin
            led_rgb = wheel_rgb;
        end else if (r_led_valid[led_addr]) begin
            led_rgb = ram_rgb;
        end else begin
            led_rgb = 24'd0;
        end
        priority if (r_byte_idx < LED_FIRST) begin
            frame_byte = rlcc_pkg::BYTE_START;
        end else if (!in_leds) begin
            frame_byte = rlcc_pkg::BYTE_END;
        end else begin
            unique case (phase)
                2'd0:    frame_byte = {rlcc_pkg::HDR_MARK, i_brightness};
                2'd1:    frame_byte = led_rgb[7:0];
                2'd2:    frame_byte = led_rgb[15:8];
                default: frame_byte = led_rgb[23:16];
            endcase
        end
    end

    // next state
    always_comb begin
        n_count      = r_count;
        n_led_valid  = r_led_valid;
        n_rainbow    = r_rainbow;
        n_wheel_pos  = r_wheel_pos;
        n_sweep_down = r_sweep_down;
        n_byte_idx   = r_byte_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        if (i_cmd.char_upd) begin
            if (r_item.rx_char == rlcc_pkg::CHAR_BS) begin
                if (r_count != 8'd0) begin
                    n_count = r_count - 8'd1;
                end
            end else if (r_count != rlcc_pkg::COUNT_MAX) begin
                n_count = r_count + 8'd1;
            end
        end

        if (i_cmd.line_end) begin
            n_count = 8'd0;
            if (line_status == rlcc_pkg::ST_RAINBOW) begin
                n_rainbow   = 1'b1;
                n_led_valid = '0;
            end else if (line_status == rlcc_pkg::ST_COLOR) begin
                n_rainbow = 1'b0;
                if (led_in_range) begin
                    n_led_valid[LED_W'(led_sel)] = 1'b1;
                end
            end
            n_out_valid = 1'b1;
            n_out = '{kind: rlcc_pkg::KIND_STATUS, out_byte: 8'd0,
                      line_status: line_status, last: 1'b1};
        end

        if (i_cmd.wheel_step && r_rainbow) begin
            if (r_wheel_pos == 8'd255) begin
                n_sweep_down = 1'b1;
            end else if (r_wheel_pos == 8'd0) begin
                n_sweep_down = 1'b0;
            end
            n_wheel_pos = n_sweep_down ? r_wheel_pos - 8'd1 : r_wheel_pos + 8'd1;
        end

        if (i_cmd.emit) begin
            n_byte_idx  = frame_last ? '0 : r_byte_idx + BYTE_W'(1);
            n_out_valid = 1'b1;
            n_out = '{kind: rlcc_pkg::KIND_STRIP, out_byte: frame_byte,
                      line_status: rlcc_pkg::ST_RAINBOW, last: frame_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= 8'd0;
            r_led_valid  <= '0;
            r_rainbow    <= 1'b0;
            r_wheel_pos  <= 8'd0;
            r_sweep_down <= 1'b0;
            r_byte_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_led_valid  <= n_led_valid;
            r_rainbow    <= n_rainbow;
            r_wheel_pos  <= n_wheel_pos;
            r_sweep_down <= n_sweep_down;
            r_byte_idx   <= n_byte_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (buf_we) begin
            r_line[r_count[IDX_W-1:0]] <= r_item.rx_char;
        end
        r_out <= n_out;
    end

    assign o_stat = '{is_tick: (r_item.cmd == rlcc_pkg::CMD_TICK),
                      is_cr: (r_item.rx_char == rlcc_pkg::CHAR_CR),
                      out_free: (!r_out_valid || i_out_ready),
                      frame_last: frame_last};

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
